[sv/record_deque_with_sort_defines.svh]
// Assertion macros for the record deque with sort.
`ifndef RECORD_DEQUE_WITH_SORT_DEFINES_SVH
`define RECORD_DEQUE_WITH_SORT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked while out of reset.
`define RDQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define RDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDQ_ASSERT(label, clk, rst_n, prop, msg)
`define RDQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[sv/rdq_pkg.sv]
// Shared types and constants for the record deque with sort.
`default_nettype none

package rdq_pkg;

  localparam int unsigned RDQ_DEPTH = 16;
  localparam logic [8:0]  GRADE_MAX = 9'd400;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SORT       = 3'd4,
    CMD_DUMP       = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLY,
    ST_DUMP_RD,
    ST_DUMP_EMIT,
    ST_SORT_RDI,
    ST_SORT_LDI,
    ST_SORT_RDJ,
    ST_SORT_CMP
  } state_e;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name;
    logic [8:0]         grade;
  } record_t;

  typedef struct packed {
    status_e status;
    logic    has_record;
    record_t rec;
    logic    last;
  } out_beat_t;

endpackage

`default_nettype wire

[sv/rdq_mem.sv]
// Record storage: one write port, one registered read port.
`default_nettype none

module rdq_mem
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = RDQ_DEPTH,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire record_t          wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output record_t               rd_data
);

  record_t mem [DEPTH];
  record_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/rdq_ctrl.sv]
// Command sequencer: ring pointers, dump walk and exchange sort over the store.
`default_nettype none

module rdq_ctrl
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = RDQ_DEPTH,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  output logic                  idle,
  input  wire logic [2:0]       cmd,
  input  wire record_t          in_rec,
  input  wire logic             out_free,
  output logic                  emit,
  output out_beat_t             beat,
  output logic                  mem_we,
  output logic [IDX_W-1:0]      mem_waddr,
  output record_t               mem_wdata,
  output logic                  mem_re,
  output logic [IDX_W-1:0]      mem_raddr,
  input  wire record_t          mem_rdata
);

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  state_e           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  record_t          cur_r, cur_nxt;
  status_e          status_r, status_nxt;
  logic             wb_pending_r;

  logic             full, empty;
  logic [IDX_W-1:0] head_dec, head_inc;
  logic [IDX_W-1:0] slot_i, slot_j, slot_back, slot_prev;
  logic             j_last, i_last;
  logic             less;

  // logical position to physical slot, one conditional subtract
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign head_dec  = (head_r == '0) ? LAST_SLOT : head_r - IDX_W'(1);
  assign head_inc  = (head_r == LAST_SLOT) ? '0 : head_r + IDX_W'(1);
  assign slot_i    = slot_of(head_r, i_r);
  assign slot_j    = slot_of(head_r, j_r);
  assign slot_back = slot_of(head_r, count_r[IDX_W-1:0]);
  // position i just finished; i has already advanced by one
  assign slot_prev = slot_of(head_r, i_r - IDX_W'(1));
  assign j_last    = (CNT_W'(j_r) + CNT_W'(1) == count_r);
  assign i_last    = (CNT_W'(i_r) + CNT_W'(2) == count_r);
  // the shared key comparator
  assign less      = (mem_rdata.key < cur_r.key);
  assign idle      = (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_POP_FRONT, CMD_POP_BACK: begin
              state_nxt = ST_REPLY;
            end
            CMD_SORT: begin
              state_nxt = (count_r < CNT_W'(2)) ? ST_REPLY : ST_SORT_RDI;
            end
            CMD_DUMP: begin
              state_nxt = empty ? ST_REPLY : ST_DUMP_RD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        state_nxt = ST_DUMP_EMIT;
      end
      ST_DUMP_EMIT: begin
        if (out_free) begin
          state_nxt = j_last ? ST_IDLE : ST_DUMP_RD;
        end
      end
      ST_SORT_RDI: begin
        state_nxt = ST_SORT_LDI;
      end
      ST_SORT_LDI: begin
        state_nxt = ST_SORT_RDJ;
      end
      ST_SORT_RDJ: begin
        state_nxt = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        // after the last j, write back position i and move on
        if (j_last) begin
          state_nxt = i_last ? ST_REPLY : ST_SORT_RDI;
        end else begin
          state_nxt = ST_SORT_RDJ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // memory controls and result beat
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = slot_i;
    mem_wdata       = cur_r;
    mem_re          = 1'b0;
    mem_raddr       = slot_j;
    emit            = 1'b0;
    beat.status     = status_r;
    beat.has_record = 1'b0;
    beat.rec        = '0;
    beat.last       = 1'b1;
    case (state_r)
      ST_IDLE: begin
        // a push writes straight from the input beat
        if (in_fire && !full &&
            (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)) begin
          mem_we    = 1'b1;
          mem_waddr = (cmd == CMD_PUSH_FRONT) ? head_dec : slot_back;
          mem_wdata = in_rec;
        end
      end
      ST_REPLY: begin
        emit = out_free;
      end
      ST_DUMP_RD: begin
        mem_re = 1'b1;
      end
      ST_DUMP_EMIT: begin
        emit            = out_free;
        beat.status     = STS_OK;
        beat.has_record = 1'b1;
        beat.rec        = mem_rdata;
        beat.last       = j_last;
      end
      ST_SORT_RDI: begin
        mem_re    = 1'b1;
        mem_raddr = slot_i;
      end
      ST_SORT_RDJ: begin
        mem_re = 1'b1;
      end
      ST_SORT_CMP: begin
        // swap: old holder of i goes to j; i itself is written at the end
        if (less) begin
          mem_we    = 1'b1;
          mem_waddr = slot_j;
          mem_wdata = cur_r;
        end
      end
      default: begin
      end
    endcase
    // held minimum returns to position i the cycle after its sweep
    if (wb_pending_r) begin
      mem_we    = 1'b1;
      mem_waddr = slot_prev;
      mem_wdata = cur_r;
    end
  end

  // pointers, counters and the held record
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cur_nxt    = cur_r;
    status_nxt = status_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          status_nxt = STS_OK;
          i_nxt      = '0;
          j_nxt      = '0;
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (full) begin
                status_nxt = STS_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                if (cmd == CMD_PUSH_FRONT) begin
                  head_nxt = head_dec;
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (empty) begin
                status_nxt = STS_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                if (cmd == CMD_POP_FRONT) begin
                  head_nxt = head_inc;
                end
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                status_nxt = STS_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP_EMIT: begin
        if (out_free && !j_last) begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_SORT_LDI: begin
        cur_nxt = mem_rdata;
        j_nxt   = i_r + IDX_W'(1);
      end
      ST_SORT_CMP: begin
        if (less) begin
          cur_nxt = mem_rdata;
        end
        if (j_last) begin
          i_nxt = i_r + IDX_W'(1);
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      status_r <= STS_OK;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cur_r <= cur_nxt;
  end

  // the held record at i returns to its slot when the j sweep ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_pending_r <= 1'b0;
    end else begin
      wb_pending_r <= (state_r == ST_SORT_CMP) && j_last;
    end
  end

endmodule

`default_nettype wire

[sv/record_deque_with_sort.sv]
// Top level of the record deque with sort: input capture, output register, checks.
`default_nettype none

// Bounded double-ended store of DEPTH records (key, name code, grade). Each
// command beat is taken only while the sequencer is idle; the result register
// lets the next command enter while a result still waits. Push and pop pass
// through an accept step and a reply step. Dump reads and then emits each
// record in turn, each read through the single registered memory read port.
// Sort walks every pair i<j with one shared signed key comparator, with
// the record at i held in a register so each exchange costs one memory write.
// Grades above 400 are saturated on push. Command codes six and seven are
// dropped without a result.
module record_deque_with_sort
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = RDQ_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [31:0] in_key,
  input  wire logic [63:0] in_name_code,
  input  wire logic [8:0]  in_grade,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_has_record,
  output logic [31:0]      out_rec_key,
  output logic [63:0]      out_rec_name,
  output logic [8:0]       out_rec_grade,
  output logic             out_last
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             in_fire;
  logic             idle;
  record_t          in_rec;
  logic             out_free;
  logic             emit;
  out_beat_t        beat;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  record_t          mem_wdata, mem_rdata;
  logic             out_valid_r;
  out_beat_t        out_r;

  assign in_ready = idle;
  assign in_fire  = in_valid && in_ready;

  // incoming record with the grade saturated
  assign in_rec.key   = $signed(in_key);
  assign in_rec.name  = in_name_code;
  assign in_rec.grade = (in_grade > GRADE_MAX) ? GRADE_MAX : in_grade;

  rdq_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .idle      (idle),
    .cmd       (in_cmd),
    .in_rec    (in_rec),
    .out_free  (out_free),
    .emit      (emit),
    .beat      (beat),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rdq_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // result register: free when empty or drained this cycle
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= beat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_has_record = out_r.has_record;
  assign out_rec_key    = out_r.rec.key;
  assign out_rec_name   = out_r.rec.name;
  assign out_rec_grade  = out_r.rec.grade;
  assign out_last       = out_r.last;

`include "record_deque_with_sort_defines.svh"

  `RDQ_ASSERT(a_emit_needs_room, clk, rst_n, emit |-> (!out_valid_r || out_ready), "result beat overwrote a waiting result")
  `RDQ_ASSERT(a_record_ok, clk, rst_n, (out_valid && out_has_record) |-> (out_status == STS_OK), "dumped record with non-ok status")
  `RDQ_ASSERT(a_single_is_last, clk, rst_n, (out_valid && !out_has_record) |-> out_last, "single result beat without last")
  `RDQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for record_deque_with_sort: predictor scoreboard, drivers, monitors.
`default_nettype none

module tb;
  import rdq_pkg::*;

  // Command codes the block drops without a result
  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;
  localparam int unsigned RANDOM_PER_PHASE = 120;
  localparam int unsigned MAX_PRINTED = 40;

  // Predicts the deque contents and queues the result beats each command should produce
  class deque_scoreboard;
    record_t     slots[RDQ_DEPTH];
    int unsigned front_slot;
    int unsigned fill;
    out_beat_t   expected_q[$];
    int unsigned mismatches, beats_checked;
    int unsigned pushes, pops, sorts, dumps, unused_cmds;
    int unsigned full_drops, empty_hits, deepest_fill, records_dumped;

    function int unsigned slot_at(int unsigned pos);
      return (front_slot + pos) % RDQ_DEPTH;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted command to the predicted store
    function void note_command(logic [2:0] cmd, logic [31:0] key, logic [63:0] name,
                               logic [8:0] grade);
      out_beat_t beat;
      record_t   tmp;
      int unsigned si, sj;
      beat = '0;
      beat.status = STS_OK;
      beat.last = 1'b1;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          pushes++;
          if (fill >= RDQ_DEPTH) begin
            beat.status = STS_FULL;
            full_drops++;
          end else begin
            if (cmd == CMD_PUSH_FRONT) begin
              front_slot = (front_slot + RDQ_DEPTH - 1) % RDQ_DEPTH;
              si = front_slot;
            end else begin
              si = slot_at(fill);
            end
            slots[si].key = key;
            slots[si].name = name;
            slots[si].grade = (grade > GRADE_MAX) ? GRADE_MAX : grade;
            fill++;
            if (fill > deepest_fill) deepest_fill = fill;
          end
          expected_q.push_back(beat);
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          pops++;
          if (fill == 0) begin
            beat.status = STS_EMPTY;
            empty_hits++;
          end else begin
            if (cmd == CMD_POP_FRONT) front_slot = (front_slot + 1) % RDQ_DEPTH;
            fill--;
          end
          expected_q.push_back(beat);
        end
        CMD_SORT: begin
          // exchange sort: position i swaps with any later j holding a strictly smaller key
          sorts++;
          for (int i = 0; i < fill; i++) begin
            for (int j = i + 1; j < fill; j++) begin
              si = slot_at(i);
              sj = slot_at(j);
              if ($signed(slots[sj].key) < $signed(slots[si].key)) begin
                tmp = slots[si];
                slots[si] = slots[sj];
                slots[sj] = tmp;
              end
            end
          end
          expected_q.push_back(beat);
        end
        CMD_DUMP: begin
          dumps++;
          if (fill == 0) begin
            beat.status = STS_EMPTY;
            empty_hits++;
            expected_q.push_back(beat);
          end else begin
            for (int i = 0; i < fill; i++) begin
              beat.has_record = 1'b1;
              beat.rec = slots[slot_at(i)];
              beat.last = (i == fill - 1);
              expected_q.push_back(beat);
              records_dumped++;
            end
          end
        end
        default: unused_cmds++;
      endcase
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                 beats_checked, what, got, want);
    endtask

    // Compare one accepted result beat against the oldest prediction
    task check_result(out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, status", got.status, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.has_record !== want.has_record)
          report_mismatch("has_record", got.has_record, want.has_record);
        if (got.rec.key !== want.rec.key) report_mismatch("rec_key", got.rec.key, want.rec.key);
        if (got.rec.name !== want.rec.name)
          report_mismatch("rec_name", got.rec.name, want.rec.name);
        if (got.rec.grade !== want.rec.grade)
          report_mismatch("rec_grade", got.rec.grade, want.rec.grade);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
      beats_checked++;
    endtask

    task flush_leftovers();
      out_beat_t want;
      while (expected_q.size() != 0) begin
        want = expected_q.pop_front();
        report_mismatch("result never arrived, status", '1, want.status);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_cmd;
  logic [31:0] in_key;
  logic [63:0] in_name_code;
  logic [8:0]  in_grade;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic        out_has_record;
  logic [31:0] out_rec_key;
  logic [63:0] out_rec_name;
  logic [8:0]  out_rec_grade;
  logic        out_last;

  int unsigned send_idle;
  int unsigned recv_idle;
  deque_scoreboard sb;

  record_deque_with_sort dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_name_code   (in_name_code),
    .in_grade       (in_grade),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_has_record (out_has_record),
    .out_rec_key    (out_rec_key),
    .out_rec_name   (out_rec_name),
    .out_rec_grade  (out_rec_grade),
    .out_last       (out_last)
  );

  // 4-unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Monitors: check result beats, then record accepted commands
  always @(posedge clk) begin : monitor
    out_beat_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_e'(out_status);
      got.has_record = out_has_record;
      got.rec.key = out_rec_key;
      got.rec.name = out_rec_name;
      got.rec.grade = out_rec_grade;
      got.last = out_last;
      sb.check_result(got);
    end
    if (rst_n && in_valid && in_ready)
      sb.note_command(in_cmd, in_key, in_name_code, in_grade);
  end

  // Drive one command beat and hold it until accepted
  task automatic issue_command(input logic [2:0] cmd, input logic [31:0] key,
                               input logic [63:0] name, input logic [8:0] grade);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_key <= key;
    in_name_code <= name;
    in_grade <= grade;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_command(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (r < 80) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    if (r < 88) return CMD_SORT;
    if (r < 97) return CMD_DUMP;
    return $urandom_range(1) ? CMD_UNUSED_B : CMD_UNUSED_A;
  endfunction

  // Keys lean on extremes and a narrow band so equal keys meet in the sort
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3, 4, 5: return $urandom_range(8) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [8:0] pick_grade();
    if ($urandom_range(3) == 0) return $urandom_range(511);
    return $urandom_range(400);
  endfunction

  // Hard stop
  initial begin
    #4000000;
    $display("record_deque_with_sort verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [2:0]  cmd;
    int unsigned n;
    int unsigned push_pct;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_SORT;
    in_key = '0;
    in_name_code = '0;
    in_grade = '0;
    out_ready = 1'b0;
    send_idle = 10;
    recv_idle = 45;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, field extremes, grade saturation, unused codes, sort and dump
    issue_command(CMD_DUMP, '0, '0, '0);
    issue_command(CMD_SORT, '0, '0, '0);
    issue_command(CMD_POP_FRONT, '0, '0, '0);
    issue_command(CMD_POP_BACK, '0, '0, '0);
    issue_command(CMD_PUSH_FRONT, 32'h8000_0000, '1, 9'd511);
    issue_command(CMD_PUSH_BACK, 32'h7fff_ffff, '0, 9'd0);
    issue_command(CMD_PUSH_FRONT, 32'hffff_ffff, 64'h0123_4567_89ab_cdef, 9'd401);
    issue_command(CMD_PUSH_BACK, 32'h0, 64'hfedc_ba98_7654_3210, 9'd400);
    issue_command(CMD_PUSH_BACK, 32'h7fff_ffff, 64'h5555_aaaa_5555_aaaa, 9'd399);
    issue_command(CMD_UNUSED_A, 32'h1234_5678, '1, 9'd7);
    issue_command(CMD_UNUSED_B, 32'h8765_4321, '1, 9'd9);
    issue_command(CMD_DUMP, '0, '0, '0);
    issue_command(CMD_SORT, '0, '0, '0);
    issue_command(CMD_DUMP, '0, '0, '0);
    issue_command(CMD_POP_FRONT, '0, '0, '0);
    issue_command(CMD_POP_BACK, '0, '0, '0);
    issue_command(CMD_DUMP, '0, '0, '0);
    issue_command(CMD_PUSH_FRONT, 32'd5, 64'haaaa_5555_aaaa_5555, 9'd256);
    issue_command(CMD_SORT, '0, '0, '0);
    issue_command(CMD_DUMP, '0, '0, '0);
    repeat (4) issue_command(CMD_POP_BACK, '0, '0, '0);
    issue_command(CMD_POP_FRONT, '0, '0, '0);

    // Random: three idling profiles, push bias swings so the store fills and drains
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 10; recv_idle = 45; end
        1: begin send_idle = 45; recv_idle = 10; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        case ((n / 24) % 3)
          0: push_pct = 70;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
        cmd = pick_command(push_pct);
        issue_command(cmd, pick_key(), {$urandom, $urandom}, pick_grade());
        if (cmd != CMD_UNUSED_A && cmd != CMD_UNUSED_B) n++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray beats
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    sb.flush_leftovers();

    $display("Ran %0d pushes, %0d pops, %0d sorts, %0d dumps, %0d unused codes; %0d beats checked",
             sb.pushes, sb.pops, sb.sorts, sb.dumps, sb.unused_cmds, sb.beats_checked);
    $display("Full-store drops %0d, empty-store reports %0d, deepest fill %0d, records dumped %0d",
             sb.full_drops, sb.empty_hits, sb.deepest_fill, sb.records_dumped);
    if (sb.mismatches == 0) begin
      $display("record_deque_with_sort verification clean");
    end else begin
      $display("record_deque_with_sort verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
